// File: rtl/bphp_pkg.sv
package bphp_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned RelW  = 4;

  localparam logic [TickW-1:0] SettleRst   = 16'd300;
  localparam logic [TickW-1:0] DcokPokRst  = 16'd2;
  localparam logic [TickW-1:0] StepRst     = 16'd20;
  localparam logic [TickW-1:0] LedDelayRst = 16'd100;
  localparam logic [RelW-1:0]  RelRst      = 4'd3;

  typedef enum logic [2:0] {
    REG_SETTLE    = 3'd0,
    REG_DCOK_POK  = 3'd1,
    REG_STEP      = 3'd2,
    REG_LED_DELAY = 3'd3,
    REG_RELEASE   = 3'd4
  } reg_idx_t;

  typedef enum logic [9:0] {
    PH_PU_SETTLE = 10'b00_0000_0001,
    PH_PU_DCOK   = 10'b00_0000_0010,
    PH_PU_POK    = 10'b00_0000_0100,
    PH_PU_LED    = 10'b00_0000_1000,
    PH_IDLE      = 10'b00_0001_0000,
    PH_RS_HOLD   = 10'b00_0010_0000,
    PH_RS_POKLOW = 10'b00_0100_0000,
    PH_RS_DCLOW  = 10'b00_1000_0000,
    PH_RS_DCOK   = 10'b01_0000_0000,
    PH_RS_POK    = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [TickW-1:0] settle;
    logic [TickW-1:0] dcok_pok;
    logic [TickW-1:0] step;
    logic [TickW-1:0] led_delay;
    logic [RelW-1:0]  release_n;
  } cfg_t;

  typedef struct packed {
    logic dc_ok;
    logic power_ok;
    logic run_enable;
    logic line_clock_enable;
    logic run_lamp;
    logic halt_lamp;
    logic sequence_busy;
  } res_t;

  // Per-button debounce controls for one tick
  typedef struct packed {
    logic step;
    logic force_set;
    logic force_clr;
  } db_ctl_t;

endpackage

// File: rtl/bphp_debounce.sv
module bphp_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bphp_pkg::db_ctl_t          ctl,
  input  logic                       level,
  input  logic [bphp_pkg::RelW-1:0]  need,
  output logic                       press,
  output logic                       latched
);

  logic                      latched_r, latched_nxt;
  logic [bphp_pkg::RelW-1:0] count_r, count_nxt;
  logic [bphp_pkg::RelW:0]   count_inc;

  assign count_inc = {1'b0, count_r} + 1'b1;
  assign press     = !latched_r && !level;
  assign latched   = latched_r;

  always_comb begin
    latched_nxt = latched_r;
    count_nxt   = count_r;
    if (ctl.force_set) begin
      latched_nxt = 1'b1;
      count_nxt   = '0;
    end else if (ctl.force_clr) begin
      latched_nxt = 1'b0;
      count_nxt   = '0;
    end else if (ctl.step) begin
      if (press) begin
        // newly latched on a pressed level: count stays at zero
        latched_nxt = 1'b1;
        count_nxt   = '0;
      end else if (latched_r) begin
        if (level) begin
          if (count_inc >= {1'b0, need}) begin
            latched_nxt = 1'b0;
            count_nxt   = '0;
          end else begin
            count_nxt = count_inc[bphp_pkg::RelW-1:0];
          end
        end else begin
          count_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      count_r   <= '0;
    end else begin
      latched_r <= latched_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// File: rtl/bphp_core.sv
module bphp_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic           reset_button,
  input  logic           halt_button,
  input  logic           aux_button,
  input  bphp_pkg::cfg_t cfg,
  output bphp_pkg::res_t res_nxt
);

  bphp_pkg::phase_t phase_r, phase_nxt;
  logic [bphp_pkg::TickW-1:0] count_r, count_nxt, limit;
  logic [bphp_pkg::TickW:0]   count_inc;
  logic done;
  logic dcok_r, pok_r, run_r, clk_on_r, run_led_r, halt_lamp_r;
  logic dcok_nxt, pok_nxt, run_nxt, clk_on_nxt, run_led_nxt, halt_lamp_nxt;
  logic [bphp_pkg::RelW-1:0] need;
  logic rst_press, hlt_press, aux_press;
  logic rst_latched, hlt_latched, aux_latched;
  bphp_pkg::db_ctl_t ctl_rst, ctl_hlt, ctl_aux;

  assign need = (cfg.release_n == '0) ? bphp_pkg::RelW'(1) : cfg.release_n;

  always_comb begin
    case (phase_r)
      bphp_pkg::PH_PU_SETTLE: limit = cfg.settle;
      bphp_pkg::PH_PU_DCOK:   limit = cfg.dcok_pok;
      bphp_pkg::PH_PU_LED:    limit = cfg.led_delay;
      bphp_pkg::PH_RS_DCOK:   limit = cfg.dcok_pok;
      default:                limit = cfg.step;
    endcase
  end

  // zero-length wait behaves as one tick
  assign count_inc = {1'b0, count_r} + 1'b1;
  assign done      = count_inc >= {1'b0, limit};

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = done ? '0 : count_inc[bphp_pkg::TickW-1:0];
    dcok_nxt      = dcok_r;
    pok_nxt       = pok_r;
    run_nxt       = run_r;
    clk_on_nxt    = clk_on_r;
    run_led_nxt   = run_led_r;
    halt_lamp_nxt = halt_lamp_r;
    ctl_rst       = '0;
    ctl_hlt       = '0;
    ctl_aux       = '0;
    case (phase_r)
      bphp_pkg::PH_PU_SETTLE: if (done) begin
        dcok_nxt  = 1'b1;
        phase_nxt = bphp_pkg::PH_PU_DCOK;
      end
      bphp_pkg::PH_PU_DCOK: if (done) begin
        pok_nxt   = 1'b1;
        phase_nxt = bphp_pkg::PH_PU_POK;
      end
      bphp_pkg::PH_PU_POK: if (done) begin
        run_led_nxt = 1'b1;
        phase_nxt   = bphp_pkg::PH_PU_LED;
      end
      bphp_pkg::PH_PU_LED: if (done) begin
        phase_nxt = bphp_pkg::PH_IDLE;
      end
      bphp_pkg::PH_RS_HOLD: if (done) begin
        run_led_nxt = 1'b0;
        pok_nxt     = 1'b0;
        phase_nxt   = bphp_pkg::PH_RS_POKLOW;
      end
      bphp_pkg::PH_RS_POKLOW: if (done) begin
        dcok_nxt  = 1'b0;
        phase_nxt = bphp_pkg::PH_RS_DCLOW;
      end
      bphp_pkg::PH_RS_DCLOW: if (done) begin
        dcok_nxt  = 1'b1;
        phase_nxt = bphp_pkg::PH_RS_DCOK;
      end
      bphp_pkg::PH_RS_DCOK: if (done) begin
        pok_nxt   = 1'b1;
        phase_nxt = bphp_pkg::PH_RS_POK;
      end
      bphp_pkg::PH_RS_POK: if (done) begin
        run_led_nxt = 1'b1;
        phase_nxt   = bphp_pkg::PH_IDLE;
      end
      default: begin
        count_nxt = count_r;
        if (rst_press) begin
          // reset press: halt and aux are not looked at on this tick
          ctl_rst.force_set = 1'b1;
          ctl_hlt.force_clr = 1'b1;
          clk_on_nxt        = 1'b1;
          run_nxt           = 1'b1;
          halt_lamp_nxt     = 1'b0;
          phase_nxt         = bphp_pkg::PH_RS_HOLD;
          count_nxt         = '0;
        end else begin
          ctl_rst.step = 1'b1;
          ctl_hlt.step = 1'b1;
          ctl_aux.step = 1'b1;
          if (hlt_press) begin
            run_nxt       = !run_r;
            halt_lamp_nxt = run_r;
          end
          if (aux_press) begin
            clk_on_nxt = !clk_on_r;
          end
        end
      end
    endcase
    if (!accept) begin
      ctl_rst = '0;
      ctl_hlt = '0;
      ctl_aux = '0;
    end
  end

  bphp_debounce u_db_rst (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_rst), .level(reset_button), .need(need),
    .press(rst_press), .latched(rst_latched)
  );

  bphp_debounce u_db_hlt (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_hlt), .level(halt_button), .need(need),
    .press(hlt_press), .latched(hlt_latched)
  );

  bphp_debounce u_db_aux (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_aux), .level(aux_button), .need(need),
    .press(aux_press), .latched(aux_latched)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= bphp_pkg::PH_PU_SETTLE;
      count_r     <= '0;
      dcok_r      <= 1'b0;
      pok_r       <= 1'b0;
      run_r       <= 1'b1;
      clk_on_r    <= 1'b1;
      run_led_r   <= 1'b0;
      halt_lamp_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      dcok_r      <= dcok_nxt;
      pok_r       <= pok_nxt;
      run_r       <= run_nxt;
      clk_on_r    <= clk_on_nxt;
      run_led_r   <= run_led_nxt;
      halt_lamp_r <= halt_lamp_nxt;
    end
  end

  always_comb begin
    res_nxt.dc_ok             = dcok_nxt;
    res_nxt.power_ok          = pok_nxt;
    res_nxt.run_enable        = run_nxt;
    res_nxt.line_clock_enable = clk_on_nxt;
    res_nxt.run_lamp          = run_led_nxt;
    res_nxt.halt_lamp         = halt_lamp_nxt;
    res_nxt.sequence_busy     = phase_nxt != bphp_pkg::PH_IDLE;
  end

  // a reset press always leaves the reset button latched
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == bphp_pkg::PH_IDLE && rst_press) |=> rst_latched)
    else $error("reset press did not latch");

  // sequence phases must not move the halt and aux debounce latches
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != bphp_pkg::PH_IDLE) |=>
      (hlt_latched == $past(hlt_latched) && aux_latched == $past(aux_latched)))
    else $error("button state moved during sequence");

  // polling only starts with both supply lines up and the run lamp on
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bphp_pkg::PH_IDLE) |-> (dcok_r && pok_r && run_led_r))
    else $error("idle with supply lines down");

endmodule

// File: rtl/bus_power_halt_panel_sequencer.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall   | reset_button, halt_button, aux_button
// out_    | output    | out_valid / out_stall | dc_ok, power_ok, run_enable,
//         |           |                       | line_clock_enable, run_lamp,
//         |           |                       | halt_lamp, sequence_busy
// cfg_    | input     | APB write, pready = 1 | five config registers at 4*i
//
// One tick transaction per clock while in_stall is low; its result appears
// in the output register on the next cycle. The phase counter and debounce
// cells update in one pass. Reset is synchronous; all state but res_r resets.
// in_stall is high only while a result waits in the output register and
// out_stall is high, so the block never stands idle on a free output.
module bus_power_halt_panel_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_reset_button,
  input  logic        in_halt_button,
  input  logic        in_aux_button,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_dc_ok,
  output logic        out_power_ok,
  output logic        out_run_enable,
  output logic        out_line_clock_enable,
  output logic        out_run_lamp,
  output logic        out_halt_lamp,
  output logic        out_sequence_busy,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bphp_pkg::cfg_t cfg_r;
  bphp_pkg::res_t res_nxt, res_r;
  bphp_pkg::reg_idx_t idx;
  logic out_valid_r;
  logic accept, wr;

  assign cfg_pready = 1'b1;
  assign idx        = bphp_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle    <= bphp_pkg::SettleRst;
      cfg_r.dcok_pok  <= bphp_pkg::DcokPokRst;
      cfg_r.step      <= bphp_pkg::StepRst;
      cfg_r.led_delay <= bphp_pkg::LedDelayRst;
      cfg_r.release_n <= bphp_pkg::RelRst;
    end else if (wr) begin
      case (idx)
        bphp_pkg::REG_SETTLE:    cfg_r.settle    <= cfg_pwdata[15:0];
        bphp_pkg::REG_DCOK_POK:  cfg_r.dcok_pok  <= cfg_pwdata[15:0];
        bphp_pkg::REG_STEP:      cfg_r.step      <= cfg_pwdata[15:0];
        bphp_pkg::REG_LED_DELAY: cfg_r.led_delay <= cfg_pwdata[15:0];
        bphp_pkg::REG_RELEASE:   cfg_r.release_n <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bphp_pkg::REG_SETTLE:    cfg_prdata = {16'd0, cfg_r.settle};
      bphp_pkg::REG_DCOK_POK:  cfg_prdata = {16'd0, cfg_r.dcok_pok};
      bphp_pkg::REG_STEP:      cfg_prdata = {16'd0, cfg_r.step};
      bphp_pkg::REG_LED_DELAY: cfg_prdata = {16'd0, cfg_r.led_delay};
      bphp_pkg::REG_RELEASE:   cfg_prdata = {28'd0, cfg_r.release_n};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  bphp_core u_core (
    .clk(clk), .rst_n(rst_n), .accept(accept),
    .reset_button(in_reset_button), .halt_button(in_halt_button),
    .aux_button(in_aux_button), .cfg(cfg_r), .res_nxt(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_dc_ok             = res_r.dc_ok;
  assign out_power_ok          = res_r.power_ok;
  assign out_run_enable        = res_r.run_enable;
  assign out_line_clock_enable = res_r.line_clock_enable;
  assign out_run_lamp          = res_r.run_lamp;
  assign out_halt_lamp         = res_r.halt_lamp;
  assign out_sequence_busy     = res_r.sequence_busy;

  // every accepted tick leaves a result behind it
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // halt lamp always mirrors the halt line
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.halt_lamp == !res_r.run_enable))
    else $error("halt lamp out of step with halt line");

  // power-OK is never up without DC-OK
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!res_r.power_ok || res_r.dc_ok))
    else $error("power-OK high with DC-OK low");

  // idle results show the run lamp on
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.sequence_busy) |-> res_r.run_lamp)
    else $error("idle without run lamp");

endmodule
